/* design/f2h_pkg.sv */
// ----------------------------------------------------------------------------
// f2h_pkg
// Shared types and constants for the binary32 to binary16 converter.
// ----------------------------------------------------------------------------
package f2h_pkg;

  localparam int SINGLE_W = 32;
  localparam int HALF_W   = 16;

  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_OVF_MIN  = 8'd143;  // rebiased exponent >= 31
  localparam logic [7:0] EXP_SUB_MIN  = 8'd102;  // rebiased exponent >= -10
  localparam logic [7:0] EXP_REBIAS   = 8'd112;  // 127 - 15
  localparam logic [4:0] HALF_EXP_MAX = 5'h1F;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_INF,
    CLS_NAN
  } f2h_class_t;

  typedef struct packed {
    logic        sgn;
    f2h_class_t  cls;
    logic [4:0]  hexp;
    logic [3:0]  sub_shift;
    logic [22:0] man;
  } f2h_dec_t;

  typedef struct packed {
    logic       sgn;
    logic [4:0] hexp;
    logic [9:0] hman;
    logic       rnd;
  } f2h_aln_t;

endpackage

/* design/f2h_decode.sv */
// ----------------------------------------------------------------------------
// f2h_decode
// Stage 1: splits the binary32 word, classifies it and rebiases the exponent.
// ----------------------------------------------------------------------------
module f2h_decode import f2h_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [SINGLE_W-1:0] up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output f2h_dec_t            dn_data
);

  logic     valid_r;
  f2h_dec_t data_r;
  f2h_dec_t data_nxt;
  logic [7:0] exp;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;
  assign exp      = up_data[30:23];

  always_comb begin
    data_nxt.sgn       = up_data[31];
    data_nxt.man       = up_data[22:0];
    data_nxt.hexp      = 5'(exp - EXP_REBIAS);
    data_nxt.sub_shift = 4'(EXP_REBIAS - exp);
    if (exp == EXP_ALL_ONES) begin
      data_nxt.cls = (up_data[22:0] == '0) ? CLS_INF : CLS_NAN;
    end else if (exp >= EXP_OVF_MIN) begin
      data_nxt.cls = CLS_INF;
    end else if (exp < EXP_SUB_MIN) begin
      data_nxt.cls = CLS_ZERO;
    end else if (exp <= EXP_REBIAS) begin
      data_nxt.cls = CLS_SUB;
    end else begin
      data_nxt.cls = CLS_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* design/f2h_align.sv */
// ----------------------------------------------------------------------------
// f2h_align
// Stage 2: selects the half mantissa and round bit, shifting subnormals.
// ----------------------------------------------------------------------------
module f2h_align import f2h_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  f2h_dec_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output f2h_aln_t dn_data
);

  logic       valid_r;
  f2h_aln_t   data_r;
  f2h_aln_t   data_nxt;
  logic [10:0] sub_sig;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // significand with implicit one, keeping the first dropped bit at the bottom
  assign sub_sig = {1'b1, up_data.man[22:13]} >> up_data.sub_shift;

  always_comb begin
    data_nxt.sgn  = up_data.sgn;
    data_nxt.hexp = '0;
    data_nxt.hman = '0;
    data_nxt.rnd  = 1'b0;
    case (up_data.cls)
      CLS_NAN: begin
        data_nxt.hexp = HALF_EXP_MAX;
        data_nxt.hman = (up_data.man[22:13] == '0) ? 10'd1 : up_data.man[22:13];
      end
      CLS_INF: begin
        data_nxt.hexp = HALF_EXP_MAX;
      end
      CLS_SUB: begin
        data_nxt.hman = sub_sig[10:1];
        data_nxt.rnd  = sub_sig[0];
      end
      CLS_NORM: begin
        data_nxt.hexp = up_data.hexp;
        data_nxt.hman = up_data.man[22:13];
        data_nxt.rnd  = up_data.man[12];
      end
      default: begin
        data_nxt.hexp = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* design/f2h_round.sv */
// ----------------------------------------------------------------------------
// f2h_round
// Stage 3: adds the round bit; the carry runs into the exponent field.
// ----------------------------------------------------------------------------
module f2h_round import f2h_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  f2h_aln_t          up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [HALF_W-1:0] dn_data
);

  logic              valid_r;
  logic [HALF_W-1:0] data_r;
  logic [HALF_W-1:0] data_nxt;
  logic [14:0]       mag;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // exponent 30 plus carry lands on infinity with a zero mantissa
  assign mag      = {up_data.hexp, up_data.hman} + 15'(up_data.rnd);
  assign data_nxt = {up_data.sgn, mag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* design/float32_to_float16_converter_top.sv */
// ----------------------------------------------------------------------------
// float32_to_float16_converter_top
// Converts binary32 bit patterns to binary16 bit patterns, one per cycle while out_tready is high.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one binary32 word per transaction on in_tdata.
//   out_* : one binary16 word per transaction on out_tdata, same order.
//   Three register stages: decode/classify, align/shift, round/pack.
//   Each word passes through the decode, align and round registers in that
//   order; out_tvalid rises once it is held in the round register.
//   Throughput is one transaction per cycle while out_tready is high; each
//   stage holds its own valid bit, so bubbles are squeezed out and
//   in_tready stays high while any stage is empty.
//   When out_tready is low, the output stage holds its word and the stages
//   behind it fill; in_tready drops only once all three stages are full.
//   Reset empties the pipeline; there is no other state.
//   Rounding adds the first dropped bit (ties away from zero); NaN payloads
//   keep their top ten bits and become 1 when those are all zero.
// ----------------------------------------------------------------------------
module float32_to_float16_converter_top import f2h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] single_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] half_bits
);

  logic     dec_valid;
  logic     dec_ready;
  f2h_dec_t dec_data;
  logic     aln_valid;
  logic     aln_ready;
  f2h_aln_t aln_data;

  f2h_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (dec_valid),
    .dn_ready (dec_ready),
    .dn_data  (dec_data)
  );

  f2h_align u_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (aln_valid),
    .dn_ready (aln_ready),
    .dn_data  (aln_data)
  );

  f2h_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (aln_valid),
    .up_ready (aln_ready),
    .up_data  (aln_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata)
  );

endmodule

/* design/f2h_checker.sv */
// ----------------------------------------------------------------------------
// f2h_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module f2h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked while output stage can drain");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 3)
      || $past(!in_tready, 1) || $past(out_tvalid && !out_tready, 2)
      || $past(in_tvalid, 3) || $past(in_tvalid, 4) || $past(!out_tready, 1))
    else $error("output appeared without a prior input transaction");

endmodule

bind float32_to_float16_converter_top f2h_checker u_f2h_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
